// ----- rtl/lcg64_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcg64_pkg
// Shared constants and types for the 64-bit LCG with skip-ahead seeding.
// ----------------------------------------------------------------------------
package lcg64_pkg;

   // Generator multiplier and increment
   localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] LCG_INC  = 64'd1;

   // Item kinds carried on req_tuser
   localparam logic KIND_NEXT      = 1'b0;
   localparam logic KIND_SEED_JUMP = 1'b1;

   // Request to the shared multiplier
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   // Response from the shared multiplier
   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

endpackage : lcg64_pkg
`default_nettype wire

// ----- rtl/lcg64_skip_ahead_generator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcg64_skip_ahead_generator
// 64-bit LCG (state' = 6364136223846793005 * state + 1 mod 2^64) with
// skip-ahead seeding from seed one.
// ----------------------------------------------------------------------------
// Each item returns one 64-bit value, the new generator state. All products
// go through one shared multiplier that forms a 64-bit product from three
// 32x32 partial products. A next item forms one product in S_ADV and then
// passes through S_OUT to the result register. A seed_jump item runs one
// round per bit of jump_count up to its highest set bit, each round two or
// three products; with jump_count 0 it goes from S_ROUND straight to S_OUT.
// The block accepts one item at a time; req_tready stays low while an item
// is at work. A finished result waits in the output register, and the next
// item may be accepted then.
// ----------------------------------------------------------------------------
module lcg64_skip_ahead_generator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [63:0] jump_count
   input  wire         req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] random_value
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ADV   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_JV    = 3'd3;
   localparam logic [2:0] S_JA    = 3'd4;
   localparam logic [2:0] S_JM    = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [63:0] gen_ff, gen_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] m_ff, m_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] v_ff, v_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        req_take;

   lcg64_pkg::mul_req_type mul_req;
   lcg64_pkg::mul_rsp_type mul_rsp;

   lcg64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   // Sequence the advance and the square-and-multiply rounds
   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      a_in         = a_ff;
      v_in         = v_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      mul_req      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_tuser == lcg64_pkg::KIND_NEXT) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = lcg64_pkg::LCG_MULT;
                  mul_req.b     = gen_ff;
                  state_in      = S_ADV;
               end else begin
                  n_in     = req_tdata;
                  m_in     = lcg64_pkg::LCG_MULT;
                  a_in     = lcg64_pkg::LCG_INC;
                  v_in     = 64'd1;
                  state_in = S_ROUND;
               end
            end
         end
         S_ADV: begin
            if (mul_rsp.done) begin
               gen_in   = mul_rsp.product + lcg64_pkg::LCG_INC;
               state_in = S_OUT;
            end
         end
         S_ROUND: begin
            // Stop once no set bit remains: v no longer changes
            if (n_ff == 64'd0) begin
               gen_in   = v_ff;
               state_in = S_OUT;
            end else if (n_ff[0]) begin
               mul_req.start = 1'b1;
               mul_req.a     = m_ff;
               mul_req.b     = v_ff;
               state_in      = S_JV;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a     = a_ff;
               mul_req.b     = m_ff + 64'd1;
               state_in      = S_JA;
            end
         end
         S_JV: begin
            if (mul_rsp.done) begin
               v_in          = mul_rsp.product + a_ff;
               mul_req.start = 1'b1;
               mul_req.a     = a_ff;
               mul_req.b     = m_ff + 64'd1;
               state_in      = S_JA;
            end
         end
         S_JA: begin
            if (mul_rsp.done) begin
               a_in          = mul_rsp.product;
               mul_req.start = 1'b1;
               mul_req.a     = m_ff;
               mul_req.b     = m_ff;
               state_in      = S_JM;
            end
         end
         S_JM: begin
            if (mul_rsp.done) begin
               m_in     = mul_rsp.product;
               n_in     = {1'b0, n_ff[63:1]};
               state_in = S_ROUND;
            end
         end
         S_OUT: begin
            // Hold until the output register is free
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = gen_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_ff       <= 64'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      m_ff        <= m_in;
      a_ff        <= a_in;
      v_ff        <= v_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule : lcg64_skip_ahead_generator
`default_nettype wire

// ----- rtl/lcg64_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcg64_mul
// Iterative 64x64 multiplier, low 64 bits of the product, built on one
// 32x32 multiplier over three partial products.
// ----------------------------------------------------------------------------
module lcg64_mul (
   input  wire                         clock,
   input  wire                         reset,
   input  wire lcg64_pkg::mul_req_type mul_req,
   output lcg64_pkg::mul_rsp_type      mul_rsp
);

   localparam logic [1:0] PH_LOLO = 2'd0;
   localparam logic [1:0] PH_LOHI = 2'd1;
   localparam logic [1:0] PH_HILO = 2'd2;
   localparam logic [1:0] PH_LAST = 2'd3;

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [1:0]  phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] op_x, op_y;

   // Pick the partial-product operands for this phase
   always_comb begin
      case (phase_ff)
         PH_LOLO: begin
            op_x = a_ff[31:0];
            op_y = b_ff[31:0];
         end
         PH_LOHI: begin
            op_x = a_ff[31:0];
            op_y = b_ff[63:32];
         end
         PH_HILO: begin
            op_x = a_ff[63:32];
            op_y = b_ff[31:0];
         end
         default: begin
            op_x = 32'd0;
            op_y = 32'd0;
         end
      endcase
   end

   // Sequence the partial products and accumulate the registered product
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      prod_in  = {32'd0, op_x} * {32'd0, op_y};
      acc_in   = acc_ff;
      if (mul_req.start) begin
         a_in     = mul_req.a;
         b_in     = mul_req.b;
         phase_in = PH_LOLO;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            PH_LOLO: ;
            PH_LOHI: acc_in = prod_ff;
            PH_HILO: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            PH_LAST: begin
               acc_in  = acc_ff + {prod_ff[31:0], 32'd0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_LOLO;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule : lcg64_mul
`default_nettype wire
